// ===== hdl/awc_pkg.sv =====
// shared constants and types for the averaged window comparator
`timescale 1ns / 1ps

package awc_pkg;

    // sample and average width of every channel
    localparam int DATA_W = 10;

    // default number of beats averaged per round
    localparam int SAMPLES_DEF = 8;

    // width of one mode band on the mode average
    localparam logic [DATA_W-1:0] BAND_STEP = 10'd255;

    // configuration port
    localparam int APB_ADDR_W = 3;
    localparam int APB_DATA_W = 32;
    localparam logic REG_DEADBAND = 1'b0;
    localparam logic [DATA_W-1:0] DEADBAND_RST = 10'd8;

    // comparison selected by the mode average
    typedef enum logic [1:0] {
        BAND_LOWER     = 2'd0,
        BAND_NOT_EQUAL = 2'd1,
        BAND_EQUAL     = 2'd2,
        BAND_HIGHER    = 2'd3
    } t_band;

endpackage

// ===== hdl/awc_if.sv =====
// stream interfaces for sample beats and result beats
`timescale 1ns / 1ps

interface awc_in_if;
    logic                       valid;
    logic                       ready;
    logic [awc_pkg::DATA_W-1:0] input_sample;
    logic [awc_pkg::DATA_W-1:0] mode_sample;
    logic [awc_pkg::DATA_W-1:0] reference_sample;

    modport source (
        output valid, input_sample, mode_sample, reference_sample,
        input  ready
    );
    modport sink (
        input  valid, input_sample, mode_sample, reference_sample,
        output ready
    );
endinterface

interface awc_res_if;
    logic                       valid;
    logic                       ready;
    logic                       output_level;
    logic                       output_changed;
    logic [awc_pkg::DATA_W-1:0] held_value;

    modport source (
        output valid, output_level, output_changed, held_value,
        input  ready
    );
    modport sink (
        input  valid, output_level, output_changed, held_value,
        output ready
    );
endinterface

// ===== hdl/averaged_window_comparator.sv =====
// averaged window comparator: per-round channel averages, hysteresis and mode compare
// the result beat of a round passes the sum register, the average register and the
// result register in turn after its last sample beat is accepted
// throughput: one sample beat per cycle; one result beat every SAMPLES beats
// a stalled result only holds the input back once all three stages are full
// reset (synchronous, active low): sums, counter, held value and last level clear,
// deadband returns to 8, all pipeline stages empty
`timescale 1ns / 1ps

module averaged_window_comparator #(
    parameter int SAMPLES = awc_pkg::SAMPLES_DEF
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,

    awc_in_if.sink                         i_smp,
    awc_res_if.source                      o_res,

    input  logic                           psel,
    input  logic                           penable,
    input  logic                           pwrite,
    input  logic [awc_pkg::APB_ADDR_W-1:0] paddr,
    input  logic [awc_pkg::APB_DATA_W-1:0] pwdata,
    output logic [awc_pkg::APB_DATA_W-1:0] prdata,
    output logic                           pready
);

    localparam int DW     = awc_pkg::DATA_W;
    // bits a round's sum can grow by
    localparam int CLOG   = (SAMPLES > 1) ? $clog2(SAMPLES) : 0;
    localparam int ACC_W  = DW + CLOG;
    localparam int CNT_W  = (SAMPLES > 1) ? $clog2(SAMPLES) : 1;
    // sum / SAMPLES as (sum * RECIP) >> SHIFT, exact for every sum below 2^ACC_W
    localparam int SHIFT  = ACC_W + CLOG;
    localparam int RCP_W  = ACC_W + 1;
    localparam int PROD_W = ACC_W + RCP_W;
    localparam logic [RCP_W-1:0] RECIP =
        RCP_W'(((64'd1 << SHIFT) + 64'(SAMPLES) - 64'd1) / 64'(SAMPLES));
    localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(SAMPLES - 1);

    // magnitude of a signed difference of two 10-bit values
    function automatic logic [DW-1:0] abs_diff(input logic signed [DW:0] x);
        logic signed [DW:0] neg;
        neg = -x;
        return x[DW] ? neg[DW-1:0] : x[DW-1:0];
    endfunction

    // ---------------------------------------------------------------
    // configuration register
    // ---------------------------------------------------------------
    logic [DW-1:0] r_deadband;
    logic          cfg_wr;

    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && (paddr[2] == awc_pkg::REG_DEADBAND);
    assign prdata = (paddr[2] == awc_pkg::REG_DEADBAND)
                  ? awc_pkg::APB_DATA_W'(r_deadband) : '0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_deadband <= awc_pkg::DEADBAND_RST;
        end else if (cfg_wr) begin
            // only the low 10 bits of a write are kept
            r_deadband <= pwdata[DW-1:0];
        end
    end

    // ---------------------------------------------------------------
    // pipeline flow control
    // ---------------------------------------------------------------
    logic r_a_vld, r_b_vld, r_out_vld;
    logic out_free, b_adv, b_free, a_adv, a_free;
    logic in_beat;

    assign out_free = !r_out_vld || o_res.ready;
    assign b_adv    = r_b_vld && out_free;
    assign b_free   = !r_b_vld || out_free;
    assign a_adv    = r_a_vld && b_free;
    assign a_free   = !r_a_vld || b_free;

    assign i_smp.ready = a_free;
    assign in_beat     = i_smp.valid && a_free;

    // ---------------------------------------------------------------
    // accumulate stage: running sums, round closes on the last beat
    // ---------------------------------------------------------------
    logic [CNT_W-1:0] r_cnt;
    logic [ACC_W-1:0] r_acc_in, r_acc_mode, r_acc_ref;
    logic [ACC_W-1:0] n_acc_in, n_acc_mode, n_acc_ref;
    logic             last_beat;

    assign last_beat  = (r_cnt == CNT_LAST);
    assign n_acc_in   = r_acc_in   + ACC_W'(i_smp.input_sample);
    assign n_acc_mode = r_acc_mode + ACC_W'(i_smp.mode_sample);
    assign n_acc_ref  = r_acc_ref  + ACC_W'(i_smp.reference_sample);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt      <= '0;
            r_acc_in   <= '0;
            r_acc_mode <= '0;
            r_acc_ref  <= '0;
        end else if (in_beat) begin
            if (last_beat) begin
                r_cnt      <= '0;
                r_acc_in   <= '0;
                r_acc_mode <= '0;
                r_acc_ref  <= '0;
            end else begin
                r_cnt      <= r_cnt + 1'b1;
                r_acc_in   <= n_acc_in;
                r_acc_mode <= n_acc_mode;
                r_acc_ref  <= n_acc_ref;
            end
        end
    end

    // completed round sums
    logic [ACC_W-1:0] r_a_sum_in, r_a_sum_mode, r_a_sum_ref;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_vld <= 1'b0;
        end else if (in_beat && last_beat) begin
            r_a_vld <= 1'b1;
        end else if (a_adv) begin
            r_a_vld <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_beat && last_beat) begin
            r_a_sum_in   <= n_acc_in;
            r_a_sum_mode <= n_acc_mode;
            r_a_sum_ref  <= n_acc_ref;
        end
    end

    // ---------------------------------------------------------------
    // average stage: reciprocal multiply, mode band decode
    // ---------------------------------------------------------------
    logic [PROD_W-1:0]   prod_in, prod_mode, prod_ref;
    logic [DW-1:0]       avg_in, avg_mode, avg_ref;
    awc_pkg::t_band      band;

    assign prod_in   = PROD_W'(r_a_sum_in)   * PROD_W'(RECIP);
    assign prod_mode = PROD_W'(r_a_sum_mode) * PROD_W'(RECIP);
    assign prod_ref  = PROD_W'(r_a_sum_ref)  * PROD_W'(RECIP);
    assign avg_in    = prod_in[SHIFT +: DW];
    assign avg_mode  = prod_mode[SHIFT +: DW];
    assign avg_ref   = prod_ref[SHIFT +: DW];

    // band edges at multiples of 255, the top three codes fold back to lower
    always_comb begin
        priority if (avg_mode <= awc_pkg::BAND_STEP) begin
            band = awc_pkg::BAND_LOWER;
        end else if (avg_mode <= DW'(2 * awc_pkg::BAND_STEP)) begin
            band = awc_pkg::BAND_NOT_EQUAL;
        end else if (avg_mode <= DW'(3 * awc_pkg::BAND_STEP)) begin
            band = awc_pkg::BAND_EQUAL;
        end else if (avg_mode <= DW'(4 * awc_pkg::BAND_STEP)) begin
            band = awc_pkg::BAND_HIGHER;
        end else begin
            band = awc_pkg::BAND_LOWER;
        end
    end

    logic [DW-1:0]  r_b_in_avg, r_b_ref_avg;
    awc_pkg::t_band r_b_band;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_b_vld <= 1'b0;
        end else if (b_free) begin
            r_b_vld <= r_a_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (a_adv) begin
            r_b_in_avg  <= avg_in;
            r_b_ref_avg <= avg_ref;
            r_b_band    <= band;
        end
    end

    // ---------------------------------------------------------------
    // decide stage: hysteresis update and window compare
    // ---------------------------------------------------------------
    logic [DW-1:0]        r_held;
    logic                 r_prev_level;
    logic signed [DW:0]   diff_hold_in, diff_hold_ref, diff_new_ref, diff_ref;
    logic                 held_upd;
    logic [DW-1:0]        n_held;
    logic [DW-1:0]        mag_ref;
    logic                 n_level;

    assign diff_hold_in  = $signed({1'b0, r_held})     - $signed({1'b0, r_b_in_avg});
    assign diff_hold_ref = $signed({1'b0, r_held})     - $signed({1'b0, r_b_ref_avg});
    assign diff_new_ref  = $signed({1'b0, r_b_in_avg}) - $signed({1'b0, r_b_ref_avg});

    // held value moves only when the new average leaves the deadband
    assign held_upd = abs_diff(diff_hold_in) > r_deadband;
    assign n_held   = held_upd ? r_b_in_avg : r_held;

    // compare runs on the updated held value
    assign diff_ref = held_upd ? diff_new_ref : diff_hold_ref;
    assign mag_ref  = abs_diff(diff_ref);

    always_comb begin
        unique case (r_b_band)
            awc_pkg::BAND_EQUAL:     n_level = mag_ref < r_deadband;
            awc_pkg::BAND_NOT_EQUAL: n_level = mag_ref > r_deadband;
            awc_pkg::BAND_HIGHER:    n_level = !diff_ref[DW] && (diff_ref != '0);
            awc_pkg::BAND_LOWER:     n_level = diff_ref[DW];
            default:                 n_level = 1'b0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_held       <= '0;
            r_prev_level <= 1'b0;
        end else if (b_adv) begin
            r_held       <= n_held;
            r_prev_level <= n_level;
        end
    end

    // ---------------------------------------------------------------
    // result register
    // ---------------------------------------------------------------
    logic          r_out_level, r_out_changed;
    logic [DW-1:0] r_out_held;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (out_free) begin
            r_out_vld <= r_b_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (b_adv) begin
            r_out_level   <= n_level;
            r_out_changed <= n_level != r_prev_level;
            r_out_held    <= n_held;
        end
    end

    assign o_res.valid          = r_out_vld;
    assign o_res.output_level   = r_out_level;
    assign o_res.output_changed = r_out_changed;
    assign o_res.held_value     = r_out_held;

endmodule

// ===== tb/averaged_window_comparator_test.sv =====
// self-checking testbench for the averaged window comparator
`timescale 1ns / 1ps

module averaged_window_comparator_test;

    // widths taken from the shared package
    localparam int DATA_W     = awc_pkg::DATA_W;
    localparam int APB_ADDR_W = awc_pkg::APB_ADDR_W;
    localparam int APB_DATA_W = awc_pkg::APB_DATA_W;

    // run length and pacing
    localparam int ROUND_LEN    = awc_pkg::SAMPLES_DEF;
    localparam int CYCLE_LIMIT  = 200000;
    localparam int DRAIN_CYCLES = 8;
    localparam int HOLD_CYCLES  = 200;
    localparam int GAP_PERCENT  = 20;
    localparam int FULL_SCALE   = (1 << DATA_W) - 1;
    localparam int STEP         = awc_pkg::BAND_STEP;

    // register map: one 32-bit register per word, the second word is unmapped
    localparam logic [APB_ADDR_W-1:0] ADDR_DEADBAND =
        APB_ADDR_W'(awc_pkg::REG_DEADBAND) << 2;
    localparam logic [APB_ADDR_W-1:0] ADDR_UNMAPPED = 3'd4;

    // how the samples of a round are shaped
    localparam int ROUND_STEADY = 0;   // every beat carries the target, exact average
    localparam int ROUND_JITTER = 1;   // small spread around the target, truncated average
    localparam int ROUND_NOISE  = 2;   // fully random samples

    // mode averages at and around every band boundary
    localparam int MODE_EDGES [10] = '{
        0, STEP, STEP + 1, 2 * STEP, 2 * STEP + 1,
        3 * STEP, 3 * STEP + 1, 4 * STEP, 4 * STEP + 1, FULL_SCALE
    };

    typedef struct {
        logic              level;
        logic              changed;
        logic [DATA_W-1:0] held;
    } t_verdict;

    logic i_clk   = 1'b0;
    logic i_rst_n = 1'b0;

    awc_in_if  smp_if ();
    awc_res_if res_if ();

    logic                  psel;
    logic                  penable;
    logic                  pwrite;
    logic [APB_ADDR_W-1:0] paddr;
    logic [APB_DATA_W-1:0] pwdata;
    logic [APB_DATA_W-1:0] prdata;
    logic                  pready;

    // scoreboard and pacing state
    t_verdict verdict_q [$];
    int       mismatch_count = 0;
    int       cycle_count    = 0;
    int       hold_left      = 0;
    bit       send_gaps_on;
    bit       recv_gaps_on;

    // predicted block state
    logic [DATA_W-1:0] cfg_deadband;
    logic [DATA_W-1:0] held_avg;
    logic              last_level;
    int                sum_input;
    int                sum_mode;
    int                sum_ref;
    int                beats_in_round;

    averaged_window_comparator DUT (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_smp   (smp_if),
        .o_res   (res_if),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    always #2 i_clk = ~i_clk;

    // watchdog: a hung pipeline or a lost result ends the run here
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("end of test: mismatches");
            $finish;
        end
    end

    // long receiver hold-off, counted down in its own process
    always @(posedge i_clk) begin
        if (hold_left != 0) begin
            hold_left <= hold_left - 1;
        end
    end

    //------------------------------------------------------------------
    // predictor
    //------------------------------------------------------------------

    function automatic logic [DATA_W-1:0] clamp10(input int v);
        if (v < 0) begin
            return '0;
        end
        if (v > FULL_SCALE) begin
            return DATA_W'(FULL_SCALE);
        end
        return DATA_W'(v);
    endfunction

    // the top sliver above four steps wraps back to the lower compare
    function automatic awc_pkg::t_band band_for(input int mode_avg);
        if (mode_avg <= STEP) begin
            return awc_pkg::BAND_LOWER;
        end
        if (mode_avg <= 2 * STEP) begin
            return awc_pkg::BAND_NOT_EQUAL;
        end
        if (mode_avg <= 3 * STEP) begin
            return awc_pkg::BAND_EQUAL;
        end
        if (mode_avg <= 4 * STEP) begin
            return awc_pkg::BAND_HIGHER;
        end
        return awc_pkg::BAND_LOWER;
    endfunction

    task automatic clear_prediction();
        cfg_deadband   = awc_pkg::DEADBAND_RST;
        held_avg       = '0;
        last_level     = 1'b0;
        sum_input      = 0;
        sum_mode       = 0;
        sum_ref        = 0;
        beats_in_round = 0;
    endtask

    // fold one accepted beat into the round; a full round queues one verdict
    task automatic absorb_beat(input logic [DATA_W-1:0] a, input logic [DATA_W-1:0] m,
                               input logic [DATA_W-1:0] r);
        int       in_avg;
        int       mode_avg;
        int       ref_avg;
        int       h;
        int       d;
        logic     level;
        t_verdict v;
        sum_input      += a;
        sum_mode       += m;
        sum_ref        += r;
        beats_in_round += 1;
        if (beats_in_round == ROUND_LEN) begin
            in_avg         = sum_input / ROUND_LEN;
            mode_avg       = sum_mode / ROUND_LEN;
            ref_avg        = sum_ref / ROUND_LEN;
            sum_input      = 0;
            sum_mode       = 0;
            sum_ref        = 0;
            beats_in_round = 0;
            // hysteresis: only a move strictly past the deadband is taken
            h = held_avg;
            d = cfg_deadband;
            if (h - d > in_avg || h + d < in_avg) begin
                held_avg = DATA_W'(in_avg);
            end
            h = held_avg;
            case (band_for(mode_avg))
                awc_pkg::BAND_EQUAL:     level = (h - d < ref_avg) && (h + d > ref_avg);
                awc_pkg::BAND_NOT_EQUAL: level = (h - d > ref_avg) || (h + d < ref_avg);
                awc_pkg::BAND_HIGHER:    level = h > ref_avg;
                default:                 level = h < ref_avg;
            endcase
            v.level    = level;
            v.changed  = level != last_level;
            v.held     = held_avg;
            last_level = level;
            verdict_q.push_back(v);
        end
    endtask

    //------------------------------------------------------------------
    // checking
    //------------------------------------------------------------------

    task automatic report_mismatch(input string what, input int got, input int want);
        mismatch_count++;
        $display("mismatch at cycle %0d: %s got %0d, wanted %0d",
                 cycle_count, what, got, want);
    endtask

    task automatic check_result();
        t_verdict v;
        if (verdict_q.size() == 0) begin
            report_mismatch("result beat with none pending, held_value", res_if.held_value, -1);
        end else begin
            v = verdict_q.pop_front();
            if (res_if.output_level !== v.level) begin
                report_mismatch("output_level", res_if.output_level, v.level);
            end
            if (res_if.output_changed !== v.changed) begin
                report_mismatch("output_changed", res_if.output_changed, v.changed);
            end
            if (res_if.held_value !== v.held) begin
                report_mismatch("held_value", res_if.held_value, v.held);
            end
        end
    endtask

    // receiver: checks the beat taken at this edge, then picks the next ready
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            res_if.ready <= 1'b0;
        end else begin
            if (res_if.valid && res_if.ready) begin
                check_result();
            end
            res_if.ready <= (hold_left == 0) &&
                            (!recv_gaps_on || $urandom_range(99) >= GAP_PERCENT);
        end
    end

    //------------------------------------------------------------------
    // drivers
    //------------------------------------------------------------------

    // offer one sample beat, with random idle cycles ahead of it when send gaps are on
    task automatic send_beat(input logic [DATA_W-1:0] a, input logic [DATA_W-1:0] m,
                             input logic [DATA_W-1:0] r);
        if (send_gaps_on) begin
            while ($urandom_range(99) < GAP_PERCENT) begin
                smp_if.valid <= 1'b0;
                @(posedge i_clk);
            end
        end
        smp_if.valid            <= 1'b1;
        smp_if.input_sample     <= a;
        smp_if.mode_sample      <= m;
        smp_if.reference_sample <= r;
        do @(posedge i_clk); while (!smp_if.ready);
        absorb_beat(a, m, r);
    endtask

    // stop offering and let every pending result come out
    task automatic wait_drained();
        smp_if.valid <= 1'b0;
        while (verdict_q.size() != 0) begin
            @(posedge i_clk);
        end
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    // setup then access phase; the register takes the value at the access edge
    task automatic write_reg(input logic [APB_ADDR_W-1:0] addr,
                             input logic [APB_DATA_W-1:0] data);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= addr;
        pwdata  <= data;
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        // only the low bits are kept; other words are dropped
        if ((addr >> 2) == APB_ADDR_W'(awc_pkg::REG_DEADBAND)) begin
            cfg_deadband = data[DATA_W-1:0];
        end
    endtask

    //------------------------------------------------------------------
    // round shaping
    //------------------------------------------------------------------

    // a value just inside, on or past the deadband around a center, or a random one
    function automatic logic [DATA_W-1:0] pick_near(input int center, input int d);
        int off;
        case ($urandom_range(6))
            0:       off = d - 1;
            1:       off = d;
            2:       off = d + 1;
            3:       off = d + 2;
            4:       off = $urandom_range(40);
            5:       off = 0;
            default: return DATA_W'($urandom_range(FULL_SCALE));
        endcase
        return $urandom_range(1) ? clamp10(center + off) : clamp10(center - off);
    endfunction

    function automatic logic [DATA_W-1:0] pick_mode();
        if ($urandom_range(1)) begin
            return DATA_W'(MODE_EDGES[$urandom_range(9)]);
        end
        return DATA_W'($urandom_range(FULL_SCALE));
    endfunction

    // one round of beats; a negative mode_force picks the mode target at random
    task automatic send_round(input int style, input int mode_force);
        logic [DATA_W-1:0] a_t;
        logic [DATA_W-1:0] m_t;
        logic [DATA_W-1:0] r_t;
        logic [DATA_W-1:0] a;
        logic [DATA_W-1:0] m;
        logic [DATA_W-1:0] r;
        int                next_held;
        int                d;
        d   = cfg_deadband;
        a_t = pick_near(held_avg, d);
        // aim the reference at the held value as it will stand after this round
        next_held = (held_avg - d > a_t || held_avg + d < a_t) ? a_t : held_avg;
        m_t = (mode_force < 0) ? pick_mode() : DATA_W'(mode_force);
        r_t = pick_near(next_held, d);
        for (int i = 0; i < ROUND_LEN; i++) begin
            case (style)
                ROUND_STEADY: begin
                    a = a_t;
                    m = m_t;
                    r = r_t;
                end
                ROUND_JITTER: begin
                    a = clamp10(a_t + int'($urandom_range(6)) - 3);
                    m = clamp10(m_t + int'($urandom_range(6)) - 3);
                    r = clamp10(r_t + int'($urandom_range(6)) - 3);
                end
                default: begin
                    a = DATA_W'($urandom_range(FULL_SCALE));
                    m = DATA_W'($urandom_range(FULL_SCALE));
                    r = DATA_W'($urandom_range(FULL_SCALE));
                end
            endcase
            send_beat(a, m, r);
        end
    endtask

    function automatic int pick_style();
        int roll;
        roll = $urandom_range(99);
        if (roll < 70) begin
            return ROUND_STEADY;
        end
        return (roll < 85) ? ROUND_JITTER : ROUND_NOISE;
    endfunction

    //------------------------------------------------------------------
    // tests
    //------------------------------------------------------------------

    // full-scale swings, both lower ranges and alternating bit patterns
    task automatic test_directed_extremes();
        // input jumps to full scale, mode in the top lower sliver, reference at zero
        for (int i = 0; i < ROUND_LEN; i++) begin
            send_beat(DATA_W'(FULL_SCALE), DATA_W'(FULL_SCALE), '0);
        end
        // input falls back to zero, mode at zero, reference at full scale
        for (int i = 0; i < ROUND_LEN; i++) begin
            send_beat('0, '0, DATA_W'(FULL_SCALE));
        end
        // checkerboard samples: every bit toggles, odd sums truncate
        for (int i = 0; i < ROUND_LEN; i++) begin
            if (i % 2 == 0) begin
                send_beat(10'h2AA, 10'h155, 10'h2AB);
            end else begin
                send_beat(10'h155, 10'h2AA, 10'h154);
            end
        end
        wait_drained();
    endtask

    // each band boundary once, steady rounds so the mode average is exact
    task automatic test_band_edges();
        for (int i = 0; i < $size(MODE_EDGES); i++) begin
            send_round(ROUND_STEADY, MODE_EDGES[i]);
        end
        wait_drained();
    endtask

    // deadband at both extremes, wide write data, and a write to an unmapped word
    task automatic test_deadband_settings();
        logic [APB_DATA_W-1:0] settings [6];
        settings[0] = '0;
        settings[1] = APB_DATA_W'(FULL_SCALE);
        settings[2] = 32'd1;
        settings[3] = 32'hFFFF_FC05;   // upper bits must be dropped
        settings[4] = APB_DATA_W'($urandom_range(FULL_SCALE));
        settings[5] = APB_DATA_W'(awc_pkg::DEADBAND_RST);
        for (int s = 0; s < 6; s++) begin
            write_reg(ADDR_DEADBAND, settings[s]);
            for (int k = 0; k < 8; k++) begin
                send_round(pick_style(), -1);
            end
            wait_drained();
        end
        // unmapped word: the deadband must stay where it is
        write_reg(ADDR_UNMAPPED, APB_DATA_W'(0));
        for (int k = 0; k < 8; k++) begin
            send_round(pick_style(), -1);
        end
        wait_drained();
    endtask

    // result side blocked for a long stretch while beats keep coming
    task automatic test_backpressure();
        send_gaps_on = 1'b0;
        hold_left   <= HOLD_CYCLES;
        for (int k = 0; k < 6; k++) begin
            send_round(ROUND_STEADY, -1);
        end
        wait_drained();
        send_gaps_on = 1'b1;
    endtask

    // mixed rounds, stray beats that shift the round boundary, a gap-free stretch
    task automatic test_random_mix();
        int strays;
        for (int k = 0; k < 32; k++) begin
            send_gaps_on = !(k >= 12 && k < 24);
            recv_gaps_on = send_gaps_on;
            if ($urandom_range(9) == 0) begin
                strays = $urandom_range(ROUND_LEN - 1, 1);
                repeat (strays) begin
                    send_beat(DATA_W'($urandom_range(FULL_SCALE)),
                              DATA_W'($urandom_range(FULL_SCALE)),
                              DATA_W'($urandom_range(FULL_SCALE)));
                end
            end
            send_round(pick_style(), -1);
        end
        send_gaps_on = 1'b1;
        recv_gaps_on = 1'b1;
        // finish any partial round so every beat has been judged
        while (beats_in_round != 0) begin
            send_beat(DATA_W'($urandom_range(FULL_SCALE)),
                      DATA_W'($urandom_range(FULL_SCALE)),
                      DATA_W'($urandom_range(FULL_SCALE)));
        end
        wait_drained();
    endtask

    initial begin
        smp_if.valid            = 1'b0;
        smp_if.input_sample     = '0;
        smp_if.mode_sample      = '0;
        smp_if.reference_sample = '0;
        res_if.ready            = 1'b0;
        psel                    = 1'b0;
        penable                 = 1'b0;
        pwrite                  = 1'b0;
        paddr                   = '0;
        pwdata                  = '0;
        send_gaps_on            = 1'b1;
        recv_gaps_on            = 1'b1;
        clear_prediction();

        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_directed_extremes();
        test_band_edges();
        test_deadband_settings();
        test_backpressure();
        test_random_mix();

        if (mismatch_count == 0) begin
            $display("end of test: clean");
        end else begin
            $display("end of test: mismatches");
        end
        $finish;
    end

endmodule
